// File: rtl/core/hrc_pkg.sv
// Shared types and constants for the hysteresis relay controller.
`default_nettype none
package hrc_pkg;

	localparam int LEVEL_W   = 12;
	localparam int CLIMATE_W = 8;
	localparam int KIND_W    = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 12;

	localparam logic [LEVEL_W:0]     ADC_MAX        = (LEVEL_W + 1)'(4095);
	localparam logic [LEVEL_W:0]     ANALOG_MARGIN  = (LEVEL_W + 1)'(50);
	localparam logic [CLIMATE_W-1:0] CLIMATE_MARGIN = CLIMATE_W'(1);

	typedef enum logic [KIND_W-1:0] {
		KIND_SENSOR = 3'd0,
		KIND_MODE   = 3'd1,
		KIND_PUMP   = 3'd2,
		KIND_LIGHT  = 3'd3,
		KIND_FAN    = 3'd4
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SOIL_THR  = 2'd0,
		REG_LIGHT_THR = 2'd1,
		REG_TEMP_THR  = 2'd2,
		REG_HUM_THR   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic manual;
		logic pump;
		logic lamp;
		logic fan;
	} relay_state_t;

	typedef struct packed {
		logic [LEVEL_W-1:0]   soil_thr;
		logic [LEVEL_W-1:0]   light_thr;
		logic [CLIMATE_W-1:0] temp_thr;
		logic [CLIMATE_W-1:0] hum_thr;
	} threshold_set_t;

endpackage
`default_nettype wire

// File: rtl/core/hrc_decide.sv
// Next relay state and mode for one registered request.
`default_nettype none
module hrc_decide (
	input  wire logic [hrc_pkg::KIND_W-1:0]    kind,
	input  wire logic [hrc_pkg::LEVEL_W-1:0]   soil_level,
	input  wire logic [hrc_pkg::LEVEL_W-1:0]   light_level,
	input  wire logic [hrc_pkg::CLIMATE_W-1:0] humidity,
	input  wire logic [hrc_pkg::CLIMATE_W-1:0] temperature,
	input  wire logic                          climate_valid,
	input  wire logic                          light_ok,
	input  wire logic                          soil_ok,
	input  wire hrc_pkg::threshold_set_t       thr,
	input  wire hrc_pkg::relay_state_t         cur,
	output hrc_pkg::relay_state_t              nxt
);

	function automatic logic analog_decide(
		input logic [hrc_pkg::LEVEL_W-1:0] level,
		input logic [hrc_pkg::LEVEL_W-1:0] t,
		input logic                        ok,
		input logic                        was_on,
		input logic                        at_or_below
	);
		logic [hrc_pkg::LEVEL_W:0] rel;
		logic [hrc_pkg::LEVEL_W:0] lvl;
		logic [hrc_pkg::LEVEL_W:0] tx;
		logic                      res;
		lvl = {1'b0, level};
		tx  = {1'b0, t};
		rel = tx + hrc_pkg::ANALOG_MARGIN;
		if (rel > hrc_pkg::ADC_MAX) begin
			rel = hrc_pkg::ADC_MAX;
		end
		if (!ok || lvl > hrc_pkg::ADC_MAX || tx > hrc_pkg::ADC_MAX) begin
			res = 1'b0;
		end else if (lvl >= rel) begin
			res = 1'b0;
		end else if (was_on) begin
			res = 1'b1;
		end else begin
			res = at_or_below ? (lvl <= tx) : (lvl < tx);
		end
		return res;
	endfunction

	function automatic logic [hrc_pkg::CLIMATE_W-1:0] release_below(
		input logic [hrc_pkg::CLIMATE_W-1:0] t
	);
		return (t > hrc_pkg::CLIMATE_MARGIN) ? t - hrc_pkg::CLIMATE_MARGIN
			: '0;
	endfunction

	logic fan_auto;
	hrc_pkg::kind_t kind_e;

	assign kind_e = hrc_pkg::kind_t'(kind);

	always_comb begin
		fan_auto = 1'b0;
		if (climate_valid) begin
			if (cur.fan) begin
				fan_auto = (temperature > release_below(thr.temp_thr))
					|| (humidity > release_below(thr.hum_thr));
			end else begin
				fan_auto = (temperature > thr.temp_thr) || (humidity > thr.hum_thr);
			end
		end
	end

	always_comb begin
		nxt = cur;
		unique case (kind_e)
			hrc_pkg::KIND_SENSOR: begin
				if (!cur.manual) begin
					nxt.pump = analog_decide(soil_level, thr.soil_thr, soil_ok,
						cur.pump, 1'b1);
					nxt.lamp = analog_decide(light_level, thr.light_thr, light_ok,
						cur.lamp, 1'b0);
					nxt.fan  = fan_auto;
				end
			end
			hrc_pkg::KIND_MODE: begin
				nxt.manual = !cur.manual;
			end
			hrc_pkg::KIND_PUMP: begin
				if (cur.manual) nxt.pump = !cur.pump;
			end
			hrc_pkg::KIND_LIGHT: begin
				if (cur.manual) nxt.lamp = !cur.lamp;
			end
			hrc_pkg::KIND_FAN: begin
				if (cur.manual) nxt.fan = !cur.fan;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/core/hysteresis_relay_controller_core.sv
// Top level of the hysteresis relay controller: request register, state and result register.
// An accepted request is held in the request register; its result is then written to the result register.
// Throughput: one request per cycle while no result is waiting or the waiting result is taken.
// A waiting result stalls the request register only when it is not taken.
// Reset (arst_n low, asynchronous) clears thresholds, mode, relays and valid flags.
`default_nettype none
module hysteresis_relay_controller_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [hrc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [hrc_pkg::CFG_W-1:0]       cfg_wdata,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [hrc_pkg::KIND_W-1:0]      kind,
	input  wire logic [hrc_pkg::LEVEL_W-1:0]     soil_level,
	input  wire logic [hrc_pkg::LEVEL_W-1:0]     light_level,
	input  wire logic [hrc_pkg::CLIMATE_W-1:0]   humidity,
	input  wire logic [hrc_pkg::CLIMATE_W-1:0]   temperature,
	input  wire logic                            climate_valid,
	input  wire logic                            light_ok,
	input  wire logic                            soil_ok,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 pump_on,
	output logic                                 lamp_on,
	output logic                                 fan_on,
	output logic                                 manual_mode
);

	hrc_pkg::threshold_set_t thr_q;
	hrc_pkg::relay_state_t   state_q;
	hrc_pkg::relay_state_t   state_nxt;
	hrc_pkg::relay_state_t   res_q;
	logic                    res_valid_q;

	logic                              valid_s1;
	logic [hrc_pkg::KIND_W-1:0]        kind_s1;
	logic [hrc_pkg::LEVEL_W-1:0]       soil_s1;
	logic [hrc_pkg::LEVEL_W-1:0]       light_s1;
	logic [hrc_pkg::CLIMATE_W-1:0]     hum_s1;
	logic [hrc_pkg::CLIMATE_W-1:0]     temp_s1;
	logic                              climate_ok_s1;
	logic                              light_ok_s1;
	logic                              soil_ok_s1;

	logic advance;
	logic in_fire;

	assign advance  = valid_s1 && (!res_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_we) begin
			unique case (hrc_pkg::cfg_reg_t'(cfg_index))
				hrc_pkg::REG_SOIL_THR:  thr_q.soil_thr  <= cfg_wdata[hrc_pkg::LEVEL_W-1:0];
				hrc_pkg::REG_LIGHT_THR: thr_q.light_thr <= cfg_wdata[hrc_pkg::LEVEL_W-1:0];
				hrc_pkg::REG_TEMP_THR:  thr_q.temp_thr  <= cfg_wdata[hrc_pkg::CLIMATE_W-1:0];
				hrc_pkg::REG_HUM_THR:   thr_q.hum_thr   <= cfg_wdata[hrc_pkg::CLIMATE_W-1:0];
				default: thr_q <= thr_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_s1       <= kind;
			soil_s1       <= soil_level;
			light_s1      <= light_level;
			hum_s1        <= humidity;
			temp_s1       <= temperature;
			climate_ok_s1 <= climate_valid;
			light_ok_s1   <= light_ok;
			soil_ok_s1    <= soil_ok;
		end
	end

	hrc_decide u_decide (
		.kind          (kind_s1),
		.soil_level    (soil_s1),
		.light_level   (light_s1),
		.humidity      (hum_s1),
		.temperature   (temp_s1),
		.climate_valid (climate_ok_s1),
		.light_ok      (light_ok_s1),
		.soil_ok       (soil_ok_s1),
		.thr           (thr_q),
		.cur           (state_q),
		.nxt           (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= state_nxt;
		end
	end

	assign out_valid   = res_valid_q;
	assign pump_on     = res_q.pump;
	assign lamp_on     = res_q.lamp;
	assign fan_on      = res_q.fan;
	assign manual_mode = res_q.manual;

endmodule
`default_nettype wire
